// ===== design/region_composition_segment_parser_assert.svh =====
// Assertion macros used by the port-level checker file.
`ifndef REGION_COMPOSITION_SEGMENT_PARSER_ASSERT_SVH
`define REGION_COMPOSITION_SEGMENT_PARSER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RCSP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsp assertion failed");

// Next-cycle implication, disabled during reset.
`define RCSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsp assertion failed");

`endif

// ===== design/rcsp_pkg.sv =====
// Shared types, codes and helpers of the region composition segment parser.
package rcsp_pkg;

    localparam int OBJECT_LIMIT = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_OBJECT = 2'd1;
    localparam logic [1:0] KIND_DONE   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_BAD_SYNC    = 3'd1;
    localparam logic [2:0] ERR_SHORT_HEAD  = 3'd2;
    localparam logic [2:0] ERR_DATA_SHORT  = 3'd3;
    localparam logic [2:0] ERR_LEN_LOW     = 3'd4;
    localparam logic [2:0] ERR_TOO_MANY    = 3'd5;
    localparam logic [2:0] ERR_ENTRY_CUT   = 3'd6;
    localparam logic [2:0] ERR_CODES_CUT   = 3'd7;

    localparam logic [7:0]  SYNC_BYTE    = 8'h0f;
    localparam logic [7:0]  SEG_TYPE_RCS = 8'h11;
    localparam logic [15:0] MIN_LENGTH   = 16'd10;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [2:0]  error_code;
        logic [15:0] id_primary;
        logic [7:0]  id_secondary;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [10:0] region_attrs;
        logic [7:0]  clut_id;
        logic [7:0]  code_first;
        logic [7:0]  code_second;
        logic [4:0]  object_count;
        logic        final_record;
    } rec_t;

    typedef struct packed {
        logic [1:0] count;
        rec_t       rec0;
        rec_t       rec1;
    } push_t;

    function automatic rec_t end_rec(logic [1:0] kind, logic [2:0] err,
                                     logic [15:0] page, logic [4:0] cnt);
        rec_t r;
        r              = '0;
        r.record_kind  = kind;
        r.error_code   = err;
        r.id_primary   = page;
        r.object_count = cnt;
        r.final_record = 1'b1;
        return r;
    endfunction

endpackage

// ===== design/region_composition_segment_parser.sv =====
// Top level of the region composition segment parser.
// Takes one byte per cycle while in_ready is high; the records that a byte completes are
// written into the record queue, and a second record of the same byte follows the first.
// in_ready falls while the four-entry record queue holds more than two records.
// Reset (rst_n low, asynchronous) empties the queue and returns the parser to idle.
module region_composition_segment_parser
    import rcsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        segment_start,
    input  logic        data_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  record_kind,
    output logic [2:0]  error_code,
    output logic [15:0] id_primary,
    output logic [7:0]  id_secondary,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [10:0] region_attrs,
    output logic [7:0]  clut_id,
    output logic [7:0]  code_first,
    output logic [7:0]  code_second,
    output logic [4:0]  object_count,
    output logic        final_record
);

    push_t push;
    rec_t  head;
    logic  room;

    assign in_ready = room;

    rcsp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (in_valid && room),
        .data_byte     (data_byte),
        .segment_start (segment_start),
        .data_end      (data_end),
        .push          (push)
    );

    rcsp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .room       (room),
        .head_valid (out_valid),
        .head_ready (out_ready),
        .head       (head)
    );

    assign record_kind  = head.record_kind;
    assign error_code   = head.error_code;
    assign id_primary   = head.id_primary;
    assign id_secondary = head.id_secondary;
    assign pos_x        = head.pos_x;
    assign pos_y        = head.pos_y;
    assign region_attrs = head.region_attrs;
    assign clut_id      = head.clut_id;
    assign code_first   = head.code_first;
    assign code_second  = head.code_second;
    assign object_count = head.object_count;
    assign final_record = head.final_record;

endmodule

// ===== design/rcsp_front.sv =====
// Byte parser: gathers segment fields and emits up to two records per beat.
module rcsp_front
    import rcsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       segment_start,
    input  logic       data_end,
    output push_t      push
);

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_SEG   = 2'd1;
    localparam logic [1:0] PH_REG   = 2'd2;
    localparam logic [1:0] PH_ENTRY = 2'd3;

    logic [1:0]  phase_reg, phase_next, phase_eff;
    logic [3:0]  idx_reg, idx_next, idx_eff, idx_inc;
    logic [15:0] rem_reg, rem_next, rem_eff, rem_dec;
    logic [15:0] page_reg, page_next, page_eff, page_new;
    logic [63:0] gather_reg, gather_next, gather_eff, g, gg;
    logic [1:0]  etype_reg, etype_next, etype_eff, etype_new;
    logic [4:0]  objs_reg, objs_next, objs_eff, objs_inc;
    logic [7:0]  region_reg, region_next, region_eff;
    logic [7:0]  attr_reg, attr_next, attr_eff;
    logic [7:0]  b6, b9;
    logic [3:0]  need;

    always_comb
    begin
        phase_eff  = phase_reg;
        idx_eff    = idx_reg;
        rem_eff    = rem_reg;
        page_eff   = page_reg;
        gather_eff = gather_reg;
        etype_eff  = etype_reg;
        objs_eff   = objs_reg;
        region_eff = region_reg;
        attr_eff   = attr_reg;
        if (segment_start)
        begin
            phase_eff  = PH_SEG;
            idx_eff    = '0;
            rem_eff    = '0;
            page_eff   = '0;
            gather_eff = '0;
            etype_eff  = '0;
            objs_eff   = '0;
            region_eff = '0;
            attr_eff   = '0;
        end

        phase_next  = phase_reg;
        idx_next    = idx_reg;
        rem_next    = rem_reg;
        page_next   = page_reg;
        gather_next = gather_reg;
        etype_next  = etype_reg;
        objs_next   = objs_reg;
        region_next = region_reg;
        attr_next   = attr_reg;
        push        = '0;

        idx_inc   = idx_eff + 4'd1;
        rem_dec   = (rem_eff != '0) ? rem_eff - 16'd1 : rem_eff;
        g         = {gather_eff[55:0], data_byte};
        page_new  = g[31:16];
        b6        = g[31:24];
        b9        = g[7:0];
        etype_new = (idx_eff == 4'd2) ? data_byte[7:6] : etype_eff;
        need      = (etype_new == 2'd1 || etype_new == 2'd2) ? 4'd8 : 4'd6;
        gg        = (need == 4'd8) ? {16'd0, g[63:16]} : g;
        objs_inc  = objs_eff + 5'd1;

        if (accept)
        begin
            phase_next  = phase_eff;
            idx_next    = idx_eff;
            rem_next    = rem_eff;
            page_next   = page_eff;
            gather_next = gather_eff;
            etype_next  = etype_eff;
            objs_next   = objs_eff;
            region_next = region_eff;
            attr_next   = attr_eff;
            unique case (phase_eff)
                PH_IDLE:
                begin
                end
                PH_SEG:
                begin
                    gather_next = g;
                    idx_next    = idx_inc;
                    if (idx_inc < 4'd6)
                    begin
                        if (data_end)
                        begin
                            push.count = 2'd1;
                            push.rec0  = end_rec(KIND_ERROR, ERR_SHORT_HEAD, page_eff,
                                                 objs_eff);
                            phase_next = PH_IDLE;
                        end
                    end
                    else if (g[47:40] != SYNC_BYTE || g[39:32] != SEG_TYPE_RCS)
                    begin
                        push.count = 2'd1;
                        push.rec0  = end_rec(KIND_ERROR, ERR_BAD_SYNC, page_eff, objs_eff);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        page_next = page_new;
                        rem_next  = g[15:0];
                        if (data_end && g[15:0] != '0)
                        begin
                            push.count = 2'd1;
                            push.rec0  = end_rec(KIND_ERROR, ERR_DATA_SHORT, page_new,
                                                 objs_eff);
                            phase_next = PH_IDLE;
                        end
                        else if (g[15:0] < MIN_LENGTH)
                        begin
                            push.count = 2'd1;
                            push.rec0  = end_rec(KIND_ERROR, ERR_LEN_LOW, page_new,
                                                 objs_eff);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next  = PH_REG;
                            idx_next    = '0;
                            gather_next = '0;
                        end
                    end
                end
                PH_REG:
                begin
                    rem_next = rem_dec;
                    idx_next = idx_inc;
                    if (idx_eff == 4'd0)
                        region_next = data_byte;
                    else if (idx_eff == 4'd1)
                        attr_next = data_byte;
                    else
                        gather_next = g;
                    if (idx_inc < 4'd10)
                    begin
                        if (data_end)
                        begin
                            push.count = 2'd1;
                            push.rec0  = end_rec(KIND_ERROR, ERR_DATA_SHORT, page_eff,
                                                 objs_eff);
                            phase_next = PH_IDLE;
                        end
                    end
                    else
                    begin
                        push.count             = 2'd1;
                        push.rec0.record_kind  = KIND_HEADER;
                        push.rec0.error_code   = ERR_NONE;
                        push.rec0.id_primary   = page_eff;
                        push.rec0.id_secondary = region_eff;
                        push.rec0.pos_x        = g[63:48];
                        push.rec0.pos_y        = g[47:32];
                        push.rec0.region_attrs = {attr_eff[7:4], attr_eff[3], b6[7:5],
                                                  b6[4:2]};
                        push.rec0.clut_id      = g[23:16];
                        push.rec0.code_first   = g[15:8];
                        push.rec0.code_second  = {2'b00, b9[7:4], b9[3:2]};
                        push.rec0.object_count = '0;
                        push.rec0.final_record = (rem_dec == '0);
                        if (rem_dec == '0)
                        begin
                            push.count = 2'd2;
                            push.rec1  = end_rec(KIND_DONE, ERR_NONE, page_eff, objs_eff);
                            phase_next = PH_IDLE;
                        end
                        else if (data_end)
                        begin
                            push.count = 2'd2;
                            push.rec1  = end_rec(KIND_ERROR, ERR_DATA_SHORT, page_eff,
                                                 objs_eff);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            phase_next  = PH_ENTRY;
                            idx_next    = '0;
                            gather_next = '0;
                        end
                    end
                end
                PH_ENTRY:
                begin
                    if (idx_eff == 4'd0 && objs_eff >= 5'(OBJECT_LIMIT))
                    begin
                        push.count = 2'd1;
                        push.rec0  = end_rec(KIND_ERROR, ERR_TOO_MANY, page_eff, objs_eff);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        rem_next    = rem_dec;
                        gather_next = g;
                        etype_next  = etype_new;
                        idx_next    = idx_inc;
                        if (idx_inc >= 4'd6 && idx_inc == need)
                        begin
                            objs_next              = objs_inc;
                            push.count             = 2'd1;
                            push.rec0.record_kind  = KIND_OBJECT;
                            push.rec0.error_code   = ERR_NONE;
                            push.rec0.id_primary   = gg[47:32];
                            push.rec0.id_secondary = {6'd0, etype_new};
                            push.rec0.pos_x        = {4'd0, gg[27:16]};
                            push.rec0.pos_y        = {4'd0, gg[11:0]};
                            push.rec0.code_first   = (need == 4'd8) ? g[15:8] : 8'd0;
                            push.rec0.code_second  = (need == 4'd8) ? g[7:0] : 8'd0;
                            push.rec0.object_count = objs_inc;
                            push.rec0.final_record = (rem_dec == '0);
                            if (rem_dec == '0)
                            begin
                                push.count = 2'd2;
                                push.rec1  = end_rec(KIND_DONE, ERR_NONE, page_eff,
                                                     objs_inc);
                                phase_next = PH_IDLE;
                            end
                            else if (data_end)
                            begin
                                push.count = 2'd2;
                                push.rec1  = end_rec(KIND_ERROR, ERR_DATA_SHORT, page_eff,
                                                     objs_inc);
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                idx_next    = '0;
                                gather_next = '0;
                            end
                        end
                        else if (rem_dec == '0)
                        begin
                            push.count = 2'd1;
                            push.rec0  = end_rec(KIND_ERROR,
                                                 (idx_inc < 4'd6) ? ERR_ENTRY_CUT
                                                                  : ERR_CODES_CUT,
                                                 page_eff, objs_eff);
                            phase_next = PH_IDLE;
                        end
                        else if (data_end)
                        begin
                            push.count = 2'd1;
                            push.rec0  = end_rec(KIND_ERROR, ERR_DATA_SHORT, page_eff,
                                                 objs_eff);
                            phase_next = PH_IDLE;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            idx_reg    <= '0;
            rem_reg    <= '0;
            page_reg   <= '0;
            gather_reg <= '0;
            etype_reg  <= '0;
            objs_reg   <= '0;
            region_reg <= '0;
            attr_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            idx_reg    <= idx_next;
            rem_reg    <= rem_next;
            page_reg   <= page_next;
            gather_reg <= gather_next;
            etype_reg  <= etype_next;
            objs_reg   <= objs_next;
            region_reg <= region_next;
            attr_reg   <= attr_next;
        end
    end

endmodule

// ===== design/rcsp_queue.sv =====
// Record queue: takes up to two records a cycle, delivers one per beat.
module rcsp_queue
    import rcsp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  push_t push,
    output logic  room,
    output logic  head_valid,
    input  logic  head_ready,
    output rec_t  head
);

    rec_t                 mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_reg, wr_next, rd_reg, rd_next, wr_second;
    logic [QUEUE_AW:0]    count_reg, count_next;
    logic                 pop;

    assign head_valid = (count_reg != '0);
    assign room       = (count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH - 2));
    assign pop        = head_valid && head_ready;
    assign head       = mem[rd_reg];
    assign wr_second  = wr_reg + QUEUE_AW'(1);

    always_comb
    begin
        wr_next    = wr_reg + QUEUE_AW'(push.count);
        rd_next    = pop ? rd_reg + QUEUE_AW'(1) : rd_reg;
        count_next = count_reg + (QUEUE_AW+1)'(push.count) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_reg] <= push.rec0;
        if (push.count == 2'd2)
            mem[wr_second] <= push.rec1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== design/rcsp_checker.sv =====
// Port-level checker of the parser, bound to the top level.
`include "region_composition_segment_parser_assert.svh"

module rcsp_checker
    import rcsp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  record_kind,
    input logic [2:0]  error_code,
    input logic [4:0]  object_count,
    input logic        final_record
);

    `RCSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(record_kind) && $stable(error_code) && $stable(final_record))
    `RCSP_ASSERT_NOW(a_error_final, clk, rst_n, out_valid && record_kind == KIND_ERROR, final_record && error_code != ERR_NONE)
    `RCSP_ASSERT_NOW(a_done_clean, clk, rst_n, out_valid && record_kind == KIND_DONE, final_record && error_code == ERR_NONE)
    `RCSP_ASSERT_NOW(a_object_count, clk, rst_n, out_valid && record_kind == KIND_OBJECT, error_code == ERR_NONE && object_count != 5'd0)

endmodule

bind region_composition_segment_parser rcsp_checker u_rcsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .record_kind  (record_kind),
    .error_code   (error_code),
    .object_count (object_count),
    .final_record (final_record)
);

// ===== verif/tb_region_composition_segment_parser.sv =====
// Testbench of the region composition segment parser: directed table, random segments, scoreboard.
module tb_region_composition_segment_parser
    import rcsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {PS_IDLE, PS_SEG_HEAD, PS_REGION, PS_OBJECT} parse_state_e;

    typedef enum int {SHAPE_EXACT, SHAPE_SHORT, SHAPE_LONG, SHAPE_LOW, SHAPE_WIDE, SHAPE_CUT}
        seg_shape_e;

    typedef struct packed {
        logic [7:0] data;
        logic       sos;
        logic       eod;
    } seg_beat_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        sos;
        logic        eod;
        logic        typed;
        logic [1:0]  kind;
        logic [2:0]  err;
        logic [15:0] page;
    } dir_row_t;

    localparam int DIR_ROWS = 23;
    localparam int PHASE_BEATS = 260;
    localparam int HOLD_CYCLES = 300;

    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{8'hff, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h0f, 1'b1, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h11, 1'b0, 1'b1, 1'b1, KIND_ERROR,  ERR_SHORT_HEAD, 16'h0000},
        '{8'h0f, 1'b1, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h11, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h0f, 1'b1, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h10, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h0a, 1'b0, 1'b0, 1'b1, KIND_ERROR,  ERR_BAD_SYNC,   16'h0000},
        '{8'h0f, 1'b1, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h11, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'hff, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'hff, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'hff, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'hff, 1'b0, 1'b1, 1'b1, KIND_ERROR,  ERR_DATA_SHORT, 16'hffff},
        '{8'h0f, 1'b1, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h11, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h12, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h34, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h00, 1'b0, 1'b0, 1'b0, KIND_HEADER, ERR_NONE,       16'h0000},
        '{8'h09, 1'b0, 1'b0, 1'b1, KIND_ERROR,  ERR_LEN_LOW,    16'h1234}
    };

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        segment_start;
    logic        data_end;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  record_kind;
    logic [2:0]  error_code;
    logic [15:0] id_primary;
    logic [7:0]  id_secondary;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [10:0] region_attrs;
    logic [7:0]  clut_id;
    logic [7:0]  code_first;
    logic [7:0]  code_second;
    logic [4:0]  object_count;
    logic        final_record;

    region_composition_segment_parser u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .segment_start (segment_start),
        .data_end      (data_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .record_kind   (record_kind),
        .error_code    (error_code),
        .id_primary    (id_primary),
        .id_secondary  (id_secondary),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .region_attrs  (region_attrs),
        .clut_id       (clut_id),
        .code_first    (code_first),
        .code_second   (code_second),
        .object_count  (object_count),
        .final_record  (final_record)
    );

    // parser mirror
    parse_state_e ps_state;
    int           ps_index;
    logic [15:0]  ps_remaining;
    logic [15:0]  ps_page;
    logic [63:0]  ps_gather;
    logic [1:0]   ps_obj_type;
    logic [4:0]   ps_objects;
    logic [7:0]   ps_region_id;
    logic [7:0]   ps_version_byte;

    rec_t      parsed_records[$];
    rec_t      awaited_records[$];
    seg_beat_t segment_beats[$];

    int fail_count;
    int beats_sent;
    int src_idle_pct;
    int sink_idle_pct;
    int kinds_seen[4];
    bit hold_request;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #1_000_000;
        $display("region_composition_segment_parser regression: fail");
        $finish;
    end

    task automatic close_segment(input logic [1:0] kind, input logic [2:0] err);
        rec_t r;
        r              = '0;
        r.record_kind  = kind;
        r.error_code   = err;
        r.id_primary   = ps_page;
        r.object_count = ps_objects;
        r.final_record = 1'b1;
        parsed_records.push_back(r);
        ps_state = PS_IDLE;
    endtask

    logic data_end_seen;

    // after a record: done if the length is used up, else data short on end of data, else on to the next object
    task automatic after_record();
        if (ps_remaining == 16'd0)
            close_segment(KIND_DONE, ERR_NONE);
        else if (data_end_seen)
            close_segment(KIND_ERROR, ERR_DATA_SHORT);
        else
        begin
            ps_state  = PS_OBJECT;
            ps_index  = 0;
            ps_gather = '0;
        end
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic sos, input logic eod);
        logic [63:0] g;
        logic [7:0]  b6;
        logic [7:0]  b9;
        rec_t        r;
        int          need;
        parsed_records.delete();
        data_end_seen = eod;
        if (sos)
        begin
            ps_index        = 0;
            ps_remaining    = '0;
            ps_page         = '0;
            ps_gather       = '0;
            ps_obj_type     = '0;
            ps_objects      = '0;
            ps_region_id    = '0;
            ps_version_byte = '0;
            ps_state        = PS_SEG_HEAD;
        end
        else if (ps_state == PS_IDLE)
            return;

        case (ps_state)
            PS_SEG_HEAD:
            begin
                ps_gather = {ps_gather[55:0], b};
                ps_index++;
                if (ps_index < 6)
                begin
                    if (eod)
                        close_segment(KIND_ERROR, ERR_SHORT_HEAD);
                    return;
                end
                g = ps_gather;
                if (g[47:40] != SYNC_BYTE || g[39:32] != SEG_TYPE_RCS)
                begin
                    close_segment(KIND_ERROR, ERR_BAD_SYNC);
                    return;
                end
                ps_page      = g[31:16];
                ps_remaining = g[15:0];
                if (eod && ps_remaining != 16'd0)
                    close_segment(KIND_ERROR, ERR_DATA_SHORT);
                else if (ps_remaining < MIN_LENGTH)
                    close_segment(KIND_ERROR, ERR_LEN_LOW);
                else
                begin
                    ps_state  = PS_REGION;
                    ps_index  = 0;
                    ps_gather = '0;
                end
            end
            PS_REGION:
            begin
                if (ps_remaining != 16'd0)
                    ps_remaining--;
                if (ps_index == 0)
                    ps_region_id = b;
                else if (ps_index == 1)
                    ps_version_byte = b;
                else
                    ps_gather = {ps_gather[55:0], b};
                ps_index++;
                if (ps_index < 10)
                begin
                    if (eod)
                        close_segment(KIND_ERROR, ERR_DATA_SHORT);
                    return;
                end
                g  = ps_gather;
                b6 = g[31:24];
                b9 = g[7:0];
                r  = '0;
                r.record_kind  = KIND_HEADER;
                r.error_code   = ERR_NONE;
                r.id_primary   = ps_page;
                r.id_secondary = ps_region_id;
                r.pos_x        = g[63:48];
                r.pos_y        = g[47:32];
                r.region_attrs = {ps_version_byte[7:4], ps_version_byte[3], b6[7:5], b6[4:2]};
                r.clut_id      = g[23:16];
                r.code_first   = g[15:8];
                r.code_second  = {2'b00, b9[7:4], b9[3:2]};
                r.final_record = (ps_remaining == 16'd0);
                parsed_records.push_back(r);
                after_record();
            end
            PS_OBJECT:
            begin
                if (ps_index == 0 && ps_objects >= OBJECT_LIMIT)
                begin
                    close_segment(KIND_ERROR, ERR_TOO_MANY);
                    return;
                end
                if (ps_remaining != 16'd0)
                    ps_remaining--;
                ps_gather = {ps_gather[55:0], b};
                if (ps_index == 2)
                    ps_obj_type = b[7:6];
                ps_index++;
                need = (ps_obj_type == 2'd1 || ps_obj_type == 2'd2) ? 8 : 6;
                if (ps_index >= 6 && ps_index == need)
                begin
                    g = ps_gather;
                    r = '0;
                    if (need == 8)
                    begin
                        r.code_first  = g[15:8];
                        r.code_second = g[7:0];
                        g = g >> 16;
                    end
                    ps_objects++;
                    r.record_kind  = KIND_OBJECT;
                    r.error_code   = ERR_NONE;
                    r.id_primary   = g[47:32];
                    r.id_secondary = {6'b0, ps_obj_type};
                    r.pos_x        = {4'b0, g[27:16]};
                    r.pos_y        = {4'b0, g[11:0]};
                    r.object_count = ps_objects;
                    r.final_record = (ps_remaining == 16'd0);
                    parsed_records.push_back(r);
                    after_record();
                    return;
                end
                if (ps_remaining == 16'd0)
                    close_segment(KIND_ERROR, ps_index < 6 ? ERR_ENTRY_CUT : ERR_CODES_CUT);
                else if (eod)
                    close_segment(KIND_ERROR, ERR_DATA_SHORT);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic send_beat(input seg_beat_t bt, input logic typed, input rec_t typed_rec);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        data_byte     = bt.data;
        segment_start = bt.sos;
        data_end      = bt.eod;
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(bt.data, bt.sos, bt.eod);
        if (typed)
            awaited_records.push_back(typed_rec);
        else
            foreach (parsed_records[i])
                awaited_records.push_back(parsed_records[i]);
        beats_sent++;
        @(negedge clk);
    endtask

    // one segment: mostly well formed with random content, some broken
    task automatic build_segment();
        logic [7:0]  body[$];
        logic [7:0]  seg[$];
        logic [7:0]  b;
        logic [1:0]  otype;
        logic [15:0] seg_len;
        logic [15:0] page;
        seg_shape_e  shape;
        seg_beat_t   bt;
        int          n_obj;
        int          r;
        int          last;
        logic        eod_last;
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3))
            begin
                bt.data = 8'($urandom_range(0, 255));
                bt.sos  = 1'b0;
                bt.eod  = 1'($urandom_range(0, 1));
                segment_beats.push_back(bt);
            end
        n_obj = ($urandom_range(0, 99) < 6) ? $urandom_range(15, 18) : $urandom_range(0, 4);
        repeat (10)
            body.push_back(8'($urandom_range(0, 255)));
        for (int i = 0; i < n_obj; i++)
        begin
            for (int j = 0; j < 6; j++)
            begin
                b = 8'($urandom_range(0, 255));
                if (j == 2)
                    otype = b[7:6];
                body.push_back(b);
            end
            if (otype == 2'd1 || otype == 2'd2)
                repeat (2)
                    body.push_back(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 99);
        if (r < 68)
            shape = SHAPE_EXACT;
        else if (r < 78)
            shape = SHAPE_SHORT;
        else if (r < 86)
            shape = SHAPE_LONG;
        else if (r < 90)
            shape = SHAPE_LOW;
        else if (r < 94)
            shape = SHAPE_WIDE;
        else
            shape = SHAPE_CUT;
        case (shape)
            SHAPE_SHORT: seg_len = 16'(body.size() - $urandom_range(1, 8));
            SHAPE_LONG:  seg_len = 16'(body.size() + $urandom_range(1, 20));
            SHAPE_LOW:   seg_len = 16'($urandom_range(0, 9));
            SHAPE_WIDE:  seg_len = 16'($urandom_range(0, 65535));
            default:     seg_len = 16'(body.size());
        endcase
        page = 16'($urandom_range(0, 65535));
        seg.push_back(($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255)) : SYNC_BYTE);
        seg.push_back(($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255)) : SEG_TYPE_RCS);
        seg.push_back(page[15:8]);
        seg.push_back(page[7:0]);
        seg.push_back(seg_len[15:8]);
        seg.push_back(seg_len[7:0]);
        foreach (body[i])
            seg.push_back(body[i]);
        last     = seg.size() - 1;
        eod_last = 1'($urandom_range(0, 1));
        if (shape == SHAPE_LONG || shape == SHAPE_WIDE)
            eod_last = 1'b1;
        if (shape == SHAPE_CUT)
            last = $urandom_range(0, seg.size() - 1);
        for (int i = 0; i <= last; i++)
        begin
            bt.data = seg[i];
            bt.sos  = (i == 0);
            bt.eod  = (i == last) && eod_last;
            segment_beats.push_back(bt);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_records.size() == 0)
            begin
                $error("record of kind %0d with none awaited", record_kind);
                fail_count++;
            end
            else
            begin
                want = awaited_records.pop_front();
                check_field("record_kind", 16'(want.record_kind), 16'(record_kind));
                check_field("error_code", 16'(want.error_code), 16'(error_code));
                check_field("id_primary", want.id_primary, id_primary);
                check_field("id_secondary", 16'(want.id_secondary), 16'(id_secondary));
                check_field("pos_x", want.pos_x, pos_x);
                check_field("pos_y", want.pos_y, pos_y);
                check_field("region_attrs", 16'(want.region_attrs), 16'(region_attrs));
                check_field("clut_id", 16'(want.clut_id), 16'(clut_id));
                check_field("code_first", 16'(want.code_first), 16'(code_first));
                check_field("code_second", 16'(want.code_second), 16'(code_second));
                check_field("object_count", 16'(want.object_count), 16'(object_count));
                check_field("final_record", 16'(want.final_record), 16'(final_record));
                kinds_seen[want.record_kind]++;
            end
        end
    end

    // receiver; a requested hold-off lets the record queue fill and stall the input
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready    = 1'b0;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            out_ready = ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    initial
    begin
        rec_t typed_rec;
        seg_beat_t bt;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        data_byte     = '0;
        segment_start = 1'b0;
        data_end      = 1'b0;
        fail_count    = 0;
        beats_sent    = 0;
        hold_request  = 1'b0;
        src_idle_pct  = 8;
        sink_idle_pct = 68;
        ps_state      = PS_IDLE;
        ps_index      = 0;
        ps_remaining  = '0;
        ps_page       = '0;
        ps_gather     = '0;
        ps_obj_type   = '0;
        ps_objects    = '0;
        ps_region_id  = '0;
        ps_version_byte = '0;
        foreach (kinds_seen[i])
            kinds_seen[i] = 0;
        repeat (12)
            @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            bt.data   = DIR_TABLE[i].data;
            bt.sos    = DIR_TABLE[i].sos;
            bt.eod    = DIR_TABLE[i].eod;
            typed_rec = '0;
            typed_rec.record_kind  = DIR_TABLE[i].kind;
            typed_rec.error_code   = DIR_TABLE[i].err;
            typed_rec.id_primary   = DIR_TABLE[i].page;
            typed_rec.final_record = 1'b1;
            send_beat(bt, DIR_TABLE[i].typed, typed_rec);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            src_idle_pct  = (ph == 0) ? 8 : (ph == 1) ? 68 : 0;
            sink_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 8 : 0;
            hold_request  = 1'b1;
            while (beats_sent < (ph + 1) * PHASE_BEATS)
            begin
                build_segment();
                while (segment_beats.size() != 0)
                    send_beat(segment_beats.pop_front(), 1'b0, '0);
            end
        end
        in_valid = 1'b0;

        while (awaited_records.size() != 0)
            @(posedge clk);
        repeat (16)
            @(posedge clk);

        $display("Sent %0d beats; checked %0d headers, %0d objects, %0d done, %0d errors",
                 beats_sent, kinds_seen[KIND_HEADER], kinds_seen[KIND_OBJECT],
                 kinds_seen[KIND_DONE], kinds_seen[KIND_ERROR]);
        $display("Ran three idling mixes with a long receiver hold-off in each.");
        if (fail_count == 0)
            $display("region_composition_segment_parser regression: pass");
        else
            $display("region_composition_segment_parser regression: fail");
        $finish;
    end

endmodule
